// ----- design/tcsb_pkg.sv -----
// ----------------------------------------------------------------------------
// tcsb_pkg
// Shared types and constants for the text console scroll buffer.
// ----------------------------------------------------------------------------
package tcsb_pkg;

  localparam int CMD_W     = 3;
  localparam int CHAR_W    = 8;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 4;
  // Cursor column holds 0..COLS inclusive, so one bit beyond the column field
  localparam int CUR_COL_W = COL_W + 1;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ROW = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7f;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0a;

  // Queue between classifier and executor (power of two)
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = QPTR_W + 1;

  // Classified operation handed to the executor
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT,
    OP_NEWLINE,
    OP_CLEAR_ALL,
    OP_CLEAR_ROW,
    OP_WRITE,
    OP_READ,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } item_t;

endpackage

// ----- design/text_console_scroll_buffer.sv -----
// ----------------------------------------------------------------------------
// text_console_scroll_buffer
// Character store with cursor, lazy wrap and scrolling, split into a
// classifying front end, an operation queue and an executing back end.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result. An item is classified on
// the cycle it is accepted and sits in a two-entry queue; the back end then
// retires one operation per cycle while the result register is free or
// being taken, except a cell read, which also passes the ST_READ state since
// the character memory has a registered read port. Scrolling and clearing
// need no extra pass: scrolling rotates a row base pointer, and clears drop
// per-cell "written" flags, so a cell never written since reset or its last
// clear reads as a space. There is no clearing pass after reset. An item
// passes a queue slot, the memory read register for reads, then the result register.
module text_console_scroll_buffer #(
  parameter int ROWS = 6,
  parameter int COLS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcsb_pkg::CMD_W-1:0]  command,
  input  logic [tcsb_pkg::CHAR_W-1:0] char_code,
  input  logic [tcsb_pkg::ROW_W-1:0]  row,
  input  logic [tcsb_pkg::COL_W-1:0]  col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcsb_pkg::ROW_W-1:0]  cursor_row,
  output logic [tcsb_pkg::COL_W-1:0]  cursor_col,
  output logic [tcsb_pkg::CHAR_W-1:0] read_char,
  output logic                        out_of_range
);

  tcsb_pkg::item_t front_item;
  tcsb_pkg::item_t q_item;
  logic            q_valid;
  logic            q_ready;

  tcsb_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .command   (command),
    .char_code (char_code),
    .row       (row),
    .col       (col),
    .item      (front_item)
  );

  tcsb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  tcsb_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col),
    .read_char    (read_char),
    .out_of_range (out_of_range)
  );

endmodule

// ----- design/tcsb_front.sv -----
// ----------------------------------------------------------------------------
// tcsb_front
// Classifies an incoming command into an executor operation, including the
// row/column range checks and printable / line-break detection.
// ----------------------------------------------------------------------------
module tcsb_front #(
  parameter int ROWS = 6,
  parameter int COLS = 14
) (
  input  logic [tcsb_pkg::CMD_W-1:0]  command,
  input  logic [tcsb_pkg::CHAR_W-1:0] char_code,
  input  logic [tcsb_pkg::ROW_W-1:0]  row,
  input  logic [tcsb_pkg::COL_W-1:0]  col,
  output tcsb_pkg::item_t             item
);

  localparam logic [tcsb_pkg::ROW_W:0] ROWS_L = (tcsb_pkg::ROW_W + 1)'(ROWS);
  localparam logic [tcsb_pkg::COL_W:0] COLS_L = (tcsb_pkg::COL_W + 1)'(COLS);

  logic row_bad;
  logic col_bad;
  logic is_break;
  logic is_print;

  assign row_bad  = {1'b0, row} >= ROWS_L;
  assign col_bad  = {1'b0, col} >= COLS_L;
  assign is_break = (char_code == tcsb_pkg::CH_CR) || (char_code == tcsb_pkg::CH_LF);
  assign is_print = (char_code >= tcsb_pkg::CH_BLANK) &&
                    (char_code <= tcsb_pkg::CH_PRINT_MAX);

  // Decode
  always_comb begin
    item.ch  = char_code;
    item.row = row;
    item.col = col;
    case (command)
      tcsb_pkg::CMD_APPEND: begin
        if (is_break)      item.op = tcsb_pkg::OP_NEWLINE;
        else if (is_print) item.op = tcsb_pkg::OP_PRINT;
        else               item.op = tcsb_pkg::OP_NOP;
      end
      tcsb_pkg::CMD_CLEAR_ALL: item.op = tcsb_pkg::OP_CLEAR_ALL;
      tcsb_pkg::CMD_CLEAR_ROW: item.op = row_bad ? tcsb_pkg::OP_BAD : tcsb_pkg::OP_CLEAR_ROW;
      tcsb_pkg::CMD_WRITE:
        item.op = (row_bad || col_bad) ? tcsb_pkg::OP_BAD : tcsb_pkg::OP_WRITE;
      tcsb_pkg::CMD_READ:
        item.op = (row_bad || col_bad) ? tcsb_pkg::OP_BAD : tcsb_pkg::OP_READ;
      default: item.op = tcsb_pkg::OP_NOP;
    endcase
  end

endmodule

// ----- design/tcsb_queue.sv -----
// ----------------------------------------------------------------------------
// tcsb_queue
// Short FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module tcsb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  tcsb_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output tcsb_pkg::item_t pop_item
);

  tcsb_pkg::item_t                slots [tcsb_pkg::QDEPTH];
  logic [tcsb_pkg::QPTR_W-1:0]    wr_ptr;
  logic [tcsb_pkg::QPTR_W-1:0]    rd_ptr;
  logic [tcsb_pkg::QCNT_W-1:0]    count;
  logic                           push;
  logic                           pop;

  assign push_ready = count != tcsb_pkg::QCNT_W'(tcsb_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ----- design/tcsb_back.sv -----
// ----------------------------------------------------------------------------
// tcsb_back
// Executes classified operations: cursor, row rotation for scrolling,
// character memory with per-cell blank flags, and the result register.
// ----------------------------------------------------------------------------
module tcsb_back #(
  parameter int ROWS = 6,
  parameter int COLS = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  tcsb_pkg::item_t                q_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcsb_pkg::ROW_W-1:0]     cursor_row,
  output logic [tcsb_pkg::COL_W-1:0]     cursor_col,
  output logic [tcsb_pkg::CHAR_W-1:0]    read_char,
  output logic                           out_of_range
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [tcsb_pkg::ROW_W:0]       ROWS_L  = (tcsb_pkg::ROW_W + 1)'(ROWS);
  localparam logic [tcsb_pkg::ROW_W-1:0]     ROWS_M1 = tcsb_pkg::ROW_W'(ROWS - 1);
  localparam logic [tcsb_pkg::CUR_COL_W-1:0] COLS_L  = tcsb_pkg::CUR_COL_W'(COLS);

  typedef enum logic {ST_RUN, ST_READ} state_t;

  state_t                            state;
  state_t                            state_next;
  logic [tcsb_pkg::ROW_W-1:0]        cur_row;
  logic [tcsb_pkg::ROW_W-1:0]        cur_row_next;
  logic [tcsb_pkg::CUR_COL_W-1:0]    cur_col;
  logic [tcsb_pkg::CUR_COL_W-1:0]    cur_col_next;
  logic [tcsb_pkg::ROW_W-1:0]        base;
  logic [tcsb_pkg::ROW_W-1:0]        base_next;
  logic [DEPTH-1:0]                  filled;
  logic [DEPTH-1:0]                  filled_next;
  logic [DEPTH-1:0]                  clr_mask;
  logic [tcsb_pkg::CHAR_W-1:0]       mem [DEPTH];
  logic [tcsb_pkg::CHAR_W-1:0]       rd_data;
  logic                              rd_filled;

  logic                              pop;
  logic                              need_nl;
  logic                              scroll;
  logic [tcsb_pkg::ROW_W-1:0]        nl_row;
  logic [tcsb_pkg::ROW_W-1:0]        base_inc;
  logic [tcsb_pkg::ROW_W-1:0]        eff_row;
  logic [tcsb_pkg::COL_W-1:0]        eff_col;
  logic [tcsb_pkg::ROW_W-1:0]        cell_row;
  logic [tcsb_pkg::COL_W-1:0]        cell_col;
  logic [AW-1:0]                     cell_addr;
  logic                              mem_we;
  logic [tcsb_pkg::CHAR_W-1:0]       mem_wdata;
  logic                              clr_all;
  logic                              clr_row_en;
  logic [tcsb_pkg::ROW_W-1:0]        clr_phys;

  // Logical row to physical row under the scroll rotation
  function automatic logic [tcsb_pkg::ROW_W-1:0] phys_row(
    input logic [tcsb_pkg::ROW_W-1:0] lr,
    input logic [tcsb_pkg::ROW_W-1:0] b
  );
    logic [tcsb_pkg::ROW_W:0] s;
    s = {1'b0, lr} + {1'b0, b};
    if (s >= ROWS_L) s = s - ROWS_L;
    return s[tcsb_pkg::ROW_W-1:0];
  endfunction

  assign q_ready  = (state == ST_RUN) && (!out_valid || out_ready);
  assign pop      = q_valid && q_ready;
  assign scroll   = cur_row == ROWS_M1;
  assign nl_row   = scroll ? ROWS_M1 : cur_row + 1'b1;
  assign base_inc = (base == ROWS_M1) ? '0 : base + 1'b1;
  assign need_nl  = (q_item.op == tcsb_pkg::OP_NEWLINE) ||
                    ((q_item.op == tcsb_pkg::OP_PRINT) && (cur_col >= COLS_L));
  assign eff_row  = need_nl ? nl_row : cur_row;
  assign eff_col  = need_nl ? '0 : cur_col[tcsb_pkg::COL_W-1:0];
  assign cell_addr = AW'(int'(phys_row(cell_row, base_next)) * COLS + int'(cell_col));

  // Per-cell row match for row clears
  for (genvar i = 0; i < DEPTH; i++) begin : g_clr
    localparam int ROW_OF = i / COLS;
    assign clr_mask[i] = clr_row_en && (int'(clr_phys) == ROW_OF);
  end

  // Operation execution
  always_comb begin
    state_next   = state;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    base_next    = base;
    cell_row     = q_item.row;
    cell_col     = q_item.col;
    mem_we       = 1'b0;
    mem_wdata    = q_item.ch;
    clr_all      = 1'b0;
    clr_row_en   = 1'b0;
    clr_phys     = base;
    if (pop) begin
      case (q_item.op)
        tcsb_pkg::OP_PRINT, tcsb_pkg::OP_NEWLINE: begin
          if (need_nl) begin
            cur_row_next = nl_row;
            if (scroll) begin
              // old top row becomes the blank bottom row
              base_next  = base_inc;
              clr_row_en = 1'b1;
              clr_phys   = base;
            end
          end
          if (q_item.op == tcsb_pkg::OP_PRINT) begin
            cell_row     = eff_row;
            cell_col     = eff_col;
            mem_we       = 1'b1;
            cur_col_next = tcsb_pkg::CUR_COL_W'(eff_col) + 1'b1;
          end else begin
            cur_col_next = '0;
          end
        end
        tcsb_pkg::OP_CLEAR_ALL: begin
          clr_all      = 1'b1;
          cur_row_next = '0;
          cur_col_next = '0;
        end
        tcsb_pkg::OP_CLEAR_ROW: begin
          clr_row_en = 1'b1;
          clr_phys   = phys_row(q_item.row, base);
        end
        tcsb_pkg::OP_WRITE: mem_we = 1'b1;
        tcsb_pkg::OP_READ:  state_next = ST_READ;
        default: ;
      endcase
    end else if (state == ST_READ) begin
      state_next = ST_RUN;
    end
  end

  // Blank flags: a clear happens before a same-cycle write
  always_comb begin
    filled_next = filled & ~clr_mask;
    if (clr_all) filled_next = '0;
    if (mem_we)  filled_next[cell_addr] = 1'b1;
  end

  // Character memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[cell_addr] <= mem_wdata;
    rd_data   <= mem[cell_addr];
    rd_filled <= filled[cell_addr];
  end

  // State, cursor and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      cur_row   <= '0;
      cur_col   <= '0;
      base      <= '0;
      filled    <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      base    <= base_next;
      filled  <= filled_next;
      if (pop && (q_item.op != tcsb_pkg::OP_READ)) begin
        out_valid    <= 1'b1;
        cursor_row   <= cur_row_next;
        cursor_col   <= cur_col_next[tcsb_pkg::COL_W-1:0];
        read_char    <= '0;
        out_of_range <= q_item.op == tcsb_pkg::OP_BAD;
      end else if (state == ST_READ) begin
        out_valid    <= 1'b1;
        cursor_row   <= cur_row;
        cursor_col   <= cur_col[tcsb_pkg::COL_W-1:0];
        read_char    <= rd_filled ? rd_data : tcsb_pkg::CH_BLANK;
        out_of_range <= 1'b0;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  // Checks
  a_row_range: assert property (@(posedge clk) disable iff (rst) cur_row <= ROWS_M1)
    else $error("cursor row beyond last row");
  a_col_range: assert property (@(posedge clk) disable iff (rst) cur_col <= COLS_L)
    else $error("cursor column beyond wrap position");
  a_base_range: assert property (@(posedge clk) disable iff (rst) base <= ROWS_M1)
    else $error("row rotation base out of range");
  a_read_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !out_valid)
    else $error("result register busy during read");
  a_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid || (state == ST_READ))
    else $error("popped operation produced no result");

endmodule
